// ----- hw/rtl/hec_pkg.sv -----
// Shared types, constants and saturating helpers for the HLL Euler cell update block.
package hec_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 24;
  localparam int NUM_BITS   = WORD_BITS + FRAC_BITS;
  localparam int CNT_BITS   = $clog2(NUM_BITS);
  localparam int SQRT_STEPS = NUM_BITS / 2;
  localparam int FIELD_BITS = 31;
  localparam int GAMMA_BITS = 26;
  localparam int DT_BITS    = 25;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t Q_ONE  = word_t'(64'd1 << FRAC_BITS);
  localparam word_t Q_HALF = word_t'(64'd1 << (FRAC_BITS - 1));
  localparam word_t W_MAX  = word_t'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam word_t W_MIN  = word_t'(64'd1 << (WORD_BITS - 1));

  localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = GAMMA_BITS'(23488102);

  typedef enum logic {
    CFG_GAMMA,
    CFG_DT_OVER_DX
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_e;

  typedef enum logic {
    DV_DIV,
    DV_SQRT
  } dv_op_e;

  typedef struct packed {
    logic  sat;
    word_t res;
  } qres_t;

  typedef struct packed {
    logic   start;
    dv_op_e op;
  } dv_req_t;

  typedef struct packed {
    logic  done;
    logic  sat;
    word_t res;
  } dv_rsp_t;

  function automatic logic [WORD_BITS-1:0] mag(input word_t a);
    logic [WORD_BITS-1:0] m;
    m = a[WORD_BITS-1] ? unsigned'(-a) : unsigned'(a);
    return m;
  endfunction

  function automatic qres_t from_mag(input logic neg, input logic [63:0] m);
    qres_t r;
    r.sat = 1'b0;
    r.res = '0;
    if (neg) begin
      if (m > 64'(unsigned'(W_MIN))) begin
        r.sat = 1'b1;
        r.res = W_MIN;
      end else begin
        r.res = word_t'({WORD_BITS{1'b0}} - m[WORD_BITS-1:0]);
      end
    end else begin
      if (m > 64'(unsigned'(W_MAX))) begin
        r.sat = 1'b1;
        r.res = W_MAX;
      end else begin
        r.res = word_t'(m[WORD_BITS-1:0]);
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/hec_alu.sv -----
// Shared saturating add, subtract and rounding multiply unit in signed fixed point.
module hec_alu (
  input  hec_pkg::alu_op_e op_i,
  input  hec_pkg::word_t   a_i,
  input  hec_pkg::word_t   b_i,
  output hec_pkg::qres_t   y_o
);

  localparam int W = hec_pkg::WORD_BITS;

  logic [W:0]   sum;
  logic [W-1:0] ma;
  logic [W-1:0] mb;
  logic [63:0]  prod;
  logic [63:0]  prod_rnd;

  always_comb begin
    sum      = '0;
    ma       = hec_pkg::mag(a_i);
    mb       = hec_pkg::mag(b_i);
    prod     = 64'(ma) * 64'(mb);
    prod_rnd = (prod + (64'd1 << (hec_pkg::FRAC_BITS - 1))) >> hec_pkg::FRAC_BITS;
    y_o.sat  = 1'b0;
    y_o.res  = '0;
    case (op_i)
      hec_pkg::ALU_ADD, hec_pkg::ALU_SUB: begin
        if (op_i == hec_pkg::ALU_ADD) begin
          sum = {a_i[W-1], a_i} + {b_i[W-1], b_i};
        end else begin
          sum = {a_i[W-1], a_i} - {b_i[W-1], b_i};
        end
        case (sum[W:W-1])
          2'b01: begin
            y_o.sat = 1'b1;
            y_o.res = hec_pkg::W_MAX;
          end
          2'b10: begin
            y_o.sat = 1'b1;
            y_o.res = hec_pkg::W_MIN;
          end
          default: y_o.res = hec_pkg::word_t'(sum[W-1:0]);
        endcase
      end
      hec_pkg::ALU_MUL: begin
        y_o = hec_pkg::from_mag(a_i[W-1] ^ b_i[W-1], prod_rnd);
      end
      default: y_o.res = '0;
    endcase
  end

endmodule

// ----- hw/rtl/hec_dvsq.sv -----
// Iterative one-bit-per-cycle divider and square root unit shared by the sequencer.
module hec_dvsq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hec_pkg::dv_req_t  req_i,
  input  hec_pkg::word_t    a_i,
  input  hec_pkg::word_t    b_i,
  output hec_pkg::dv_rsp_t  rsp_o
);

  localparam int W = hec_pkg::WORD_BITS;
  localparam int N = hec_pkg::NUM_BITS;
  localparam int F = hec_pkg::FRAC_BITS;

  logic                      busy_q;
  logic                      fin_q;
  hec_pkg::dv_op_e           op_q;
  logic                      neg_q;
  logic                      dz_q;
  logic [hec_pkg::CNT_BITS-1:0] cnt_q;
  logic [N-1:0]              rem_q;
  logic [N-1:0]              quo_q;
  logic [N-1:0]              bit_q;
  logic [W-1:0]              mb_q;

  logic [W-1:0]   ma_s;
  logic [W-1:0]   mb_s;
  logic [W:0]     rsh;
  logic           ge;
  logic [N-1:0]   trial;
  hec_pkg::qres_t fm;

  always_comb begin
    ma_s  = hec_pkg::mag(a_i);
    mb_s  = hec_pkg::mag(b_i);
    rsh   = {rem_q[W-1:0], quo_q[N-1]};
    ge    = rsh >= {1'b0, mb_q};
    trial = quo_q + bit_q;
    fm    = hec_pkg::from_mag(neg_q, 64'(quo_q));
  end

  assign rsp_o.done = fin_q;
  assign rsp_o.sat  = dz_q | fm.sat;
  assign rsp_o.res  = fm.res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.op == hec_pkg::DV_DIV && mb_s == '0) begin
          fin_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= (req_i.op == hec_pkg::DV_DIV) ? hec_pkg::CNT_BITS'(N - 1)
                                                  : hec_pkg::CNT_BITS'(hec_pkg::SQRT_STEPS - 1);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q <= req_i.op;
      mb_q <= mb_s;
      if (req_i.op == hec_pkg::DV_DIV) begin
        neg_q <= a_i[W-1] ^ b_i[W-1];
        dz_q  <= (mb_s == '0);
        rem_q <= '0;
        quo_q <= (mb_s == '0) ? '0 : N'({ma_s, {F{1'b0}}}) + N'(mb_s >> 1);
        bit_q <= '0;
      end else begin
        neg_q <= 1'b0;
        dz_q  <= 1'b0;
        rem_q <= a_i[W-1] ? '0 : N'({a_i, {F{1'b0}}});
        quo_q <= '0;
        bit_q <= N'(1) << (N - 2);
      end
    end else if (busy_q) begin
      if (op_q == hec_pkg::DV_DIV) begin
        rem_q <= ge ? N'(rsh - {1'b0, mb_q}) : N'(rsh);
        quo_q <= {quo_q[N-2:0], ge};
      end else begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          quo_q <= (quo_q >> 1) + bit_q;
        end else begin
          quo_q <= quo_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q && !fin_q)
    else $error("divider started while busy");
  a_busy_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && fin_q))
    else $error("divider busy and finishing at once");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> !fin_q)
    else $error("divider done held longer than one cycle");

endmodule

// ----- hw/rtl/hll_euler_cell_update.sv -----
// Top level: sequencer, operand registers and output stage of the HLL Euler cell update.
// Each cell waits on the shared divide and square root unit, which resolves one bit per
// cycle (two divisions and a square root per cell, and up to three divisions for the HLL
// blend). A first cell of a row returns to idle with no result; a result is presented from
// the third cell of a row on. Items are taken one at a time; stall is high unless idle.
// Reset clears the row state, sets gamma to 1.4 and dt_over_dx to zero.
module hll_euler_cell_update (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [hec_pkg::GAMMA_BITS-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [hec_pkg::FIELD_BITS-1:0]      density_i,
  input  logic signed [hec_pkg::WORD_BITS-1:0] momentum_i,
  input  logic [hec_pkg::FIELD_BITS-1:0]      energy_i,
  input  logic                                row_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [hec_pkg::FIELD_BITS-1:0]      new_density_o,
  output logic signed [hec_pkg::WORD_BITS-1:0] new_momentum_o,
  output logic [hec_pkg::FIELD_BITS-1:0]      new_energy_o,
  output logic                                fault_o,
  output logic                                last_cell_o
);

  localparam int W = hec_pkg::WORD_BITS;

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_VEL    = 6'd1;
  localparam logic [5:0] S_MV     = 6'd2;
  localparam logic [5:0] S_KE     = 6'd3;
  localparam logic [5:0] S_ED     = 6'd4;
  localparam logic [5:0] S_GM     = 6'd5;
  localparam logic [5:0] S_PRES   = 6'd6;
  localparam logic [5:0] S_GP     = 6'd7;
  localparam logic [5:0] S_GPR    = 6'd8;
  localparam logic [5:0] S_SND    = 6'd9;
  localparam logic [5:0] S_F1     = 6'd10;
  localparam logic [5:0] S_EP     = 6'd11;
  localparam logic [5:0] S_F2     = 6'd12;
  localparam logic [5:0] S_SL     = 6'd13;
  localparam logic [5:0] S_SR     = 6'd14;
  localparam logic [5:0] S_K      = 6'd15;
  localparam logic [5:0] S_MA     = 6'd16;
  localparam logic [5:0] S_MB     = 6'd17;
  localparam logic [5:0] S_B1     = 6'd18;
  localparam logic [5:0] S_B2     = 6'd19;
  localparam logic [5:0] S_B3     = 6'd20;
  localparam logic [5:0] S_B4     = 6'd21;
  localparam logic [5:0] S_B5     = 6'd22;
  localparam logic [5:0] S_B6     = 6'd23;
  localparam logic [5:0] S_B7     = 6'd24;
  localparam logic [5:0] S_B8     = 6'd25;
  localparam logic [5:0] S_B9     = 6'd26;
  localparam logic [5:0] S_IFLT   = 6'd27;
  localparam logic [5:0] S_U1     = 6'd28;
  localparam logic [5:0] S_U2     = 6'd29;
  localparam logic [5:0] S_U3     = 6'd30;
  localparam logic [5:0] S_OUT    = 6'd31;
  localparam logic [5:0] S_COMMIT = 6'd32;

  logic [5:0] pc_q;
  logic [1:0] k_q;
  logic [1:0] cells_q;
  logic       lwait_q;
  logic       sat_q;
  logic       cfault_q;
  logic       pcfault_q;
  logic       cif_q;
  logic       pif_flt_q;
  logic       out_valid_q;
  logic [hec_pkg::GAMMA_BITS-1:0] gamma_q;
  logic [hec_pkg::DT_BITS-1:0]    dt_q;

  hec_pkg::word_t cu0_q, cu1_q, cu2_q;
  hec_pkg::word_t vel_q, pres_q, snd_q, cf1_q, cf2_q;
  hec_pkg::word_t t1_q, t2_q, t3_q, ta_q, tb_q, sl_q, sr_q;
  hec_pkg::word_t fc0_q, fc1_q, fc2_q;
  hec_pkg::word_t pu0_q, pu1_q, pu2_q, pvel_q, psnd_q;
  hec_pkg::word_t pf0_q, pf1_q, pf2_q, pif0_q, pif1_q, pif2_q;
  hec_pkg::word_t nv0_q, nv1_q, nv2_q;
  logic           row_end_q;
  logic [hec_pkg::FIELD_BITS-1:0] od_q, oe_q;
  hec_pkg::word_t om_q;
  logic           of_q, ol_q;

  hec_pkg::alu_op_e alu_op;
  hec_pkg::word_t   alu_a, alu_b;
  hec_pkg::qres_t   alu_y;
  logic             uses_alu;
  hec_pkg::dv_req_t dv_req;
  hec_pkg::dv_op_e  dv_op;
  hec_pkg::word_t   dv_a, dv_b;
  hec_pkg::dv_rsp_t dv_rsp;
  logic             long_step;

  hec_pkg::word_t pf_k, cf_k, cu_k, pu_k, pif_k, fc_k;
  hec_pkg::word_t gamma_w, dt_w;
  logic in_acc, rho_zero, pres_nonpos, snd_skip, sl_pos, sr_neg, sr_eq_sl;
  logic k_last, out_free, step_sat, fc_we;
  hec_pkg::word_t fc_wd;

  assign in_acc      = in_valid_i && (pc_q == S_IDLE);
  assign in_stall_o  = (pc_q != S_IDLE);
  assign gamma_w     = hec_pkg::word_t'({{(W - hec_pkg::GAMMA_BITS){1'b0}}, gamma_q});
  assign dt_w        = hec_pkg::word_t'({{(W - hec_pkg::DT_BITS){1'b0}}, dt_q});
  assign rho_zero    = (cu0_q == '0);
  assign pres_nonpos = pres_q[W-1] || (pres_q == '0);
  assign snd_skip    = rho_zero || pres_nonpos;
  assign sl_pos      = !sl_q[W-1] && (sl_q != '0);
  assign sr_neg      = sr_q[W-1];
  assign sr_eq_sl    = (sr_q == sl_q);
  assign k_last      = (k_q == 2'd2);
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    case (k_q)
      2'd0: begin
        pf_k = pf0_q; cf_k = cu1_q; cu_k = cu0_q; pu_k = pu0_q; pif_k = pif0_q; fc_k = fc0_q;
      end
      2'd1: begin
        pf_k = pf1_q; cf_k = cf1_q; cu_k = cu1_q; pu_k = pu1_q; pif_k = pif1_q; fc_k = fc1_q;
      end
      default: begin
        pf_k = pf2_q; cf_k = cf2_q; cu_k = cu2_q; pu_k = pu2_q; pif_k = pif2_q; fc_k = fc2_q;
      end
    endcase
  end

  always_comb begin
    alu_op   = hec_pkg::ALU_ADD;
    alu_a    = '0;
    alu_b    = '0;
    uses_alu = 1'b1;
    dv_a     = '0;
    dv_b     = '0;
    dv_op    = hec_pkg::DV_DIV;
    case (pc_q)
      S_VEL: begin
        uses_alu = 1'b0; dv_a = cu1_q; dv_b = cu0_q;
      end
      S_MV:   begin alu_op = hec_pkg::ALU_MUL; alu_a = cu1_q;   alu_b = vel_q;        end
      S_KE:   begin alu_op = hec_pkg::ALU_MUL; alu_a = t1_q;    alu_b = hec_pkg::Q_HALF; end
      S_ED:   begin alu_op = hec_pkg::ALU_SUB; alu_a = cu2_q;   alu_b = t2_q;         end
      S_GM:   begin alu_op = hec_pkg::ALU_SUB; alu_a = gamma_w; alu_b = hec_pkg::Q_ONE; end
      S_PRES: begin alu_op = hec_pkg::ALU_MUL; alu_a = t3_q;    alu_b = t2_q;         end
      S_GP: begin
        alu_op = hec_pkg::ALU_MUL; alu_a = gamma_w; alu_b = pres_q; uses_alu = !snd_skip;
      end
      S_GPR: begin
        uses_alu = 1'b0; dv_a = t3_q; dv_b = cu0_q;
      end
      S_SND: begin
        uses_alu = 1'b0; dv_a = t3_q; dv_op = hec_pkg::DV_SQRT;
      end
      S_F1: begin alu_op = hec_pkg::ALU_ADD; alu_a = t1_q;   alu_b = pres_q; end
      S_EP: begin alu_op = hec_pkg::ALU_ADD; alu_a = cu2_q;  alu_b = pres_q; end
      S_F2: begin alu_op = hec_pkg::ALU_MUL; alu_a = vel_q;  alu_b = t2_q;   end
      S_SL: begin alu_op = hec_pkg::ALU_SUB; alu_a = pvel_q; alu_b = psnd_q; end
      S_SR: begin alu_op = hec_pkg::ALU_ADD; alu_a = vel_q;  alu_b = snd_q;  end
      S_MA: begin alu_op = hec_pkg::ALU_ADD; alu_a = pf_k;   alu_b = cf_k;   end
      S_MB: begin alu_op = hec_pkg::ALU_MUL; alu_a = t1_q;   alu_b = hec_pkg::Q_HALF; end
      S_B1: begin alu_op = hec_pkg::ALU_MUL; alu_a = sr_q;   alu_b = pf_k;   end
      S_B2: begin alu_op = hec_pkg::ALU_MUL; alu_a = sl_q;   alu_b = cf_k;   end
      S_B3: begin alu_op = hec_pkg::ALU_SUB; alu_a = ta_q;   alu_b = tb_q;   end
      S_B4: begin alu_op = hec_pkg::ALU_MUL; alu_a = sl_q;   alu_b = sr_q;   end
      S_B5: begin alu_op = hec_pkg::ALU_SUB; alu_a = cu_k;   alu_b = pu_k;   end
      S_B6: begin alu_op = hec_pkg::ALU_MUL; alu_a = tb_q;   alu_b = t2_q;   end
      S_B7: begin alu_op = hec_pkg::ALU_ADD; alu_a = ta_q;   alu_b = tb_q;   end
      S_B8: begin alu_op = hec_pkg::ALU_SUB; alu_a = sr_q;   alu_b = sl_q;   end
      S_B9: begin
        uses_alu = 1'b0; dv_a = ta_q; dv_b = tb_q;
      end
      S_U1: begin alu_op = hec_pkg::ALU_SUB; alu_a = fc_k;   alu_b = pif_k;  end
      S_U2: begin alu_op = hec_pkg::ALU_MUL; alu_a = dt_w;   alu_b = t1_q;   end
      S_U3: begin alu_op = hec_pkg::ALU_SUB; alu_a = pu_k;   alu_b = t1_q;   end
      default: uses_alu = 1'b0;
    endcase
  end

  assign long_step = ((pc_q == S_VEL) && !rho_zero) || (pc_q == S_GPR) ||
                     (pc_q == S_SND) || (pc_q == S_B9);
  assign dv_req    = '{start: long_step && !lwait_q, op: dv_op};
  assign step_sat = (uses_alu && alu_y.sat) || (long_step && dv_rsp.done && dv_rsp.sat);

  always_comb begin
    fc_we = 1'b0;
    fc_wd = alu_y.res;
    case (pc_q)
      S_K: begin
        if (sl_pos) begin
          fc_we = 1'b1; fc_wd = pf_k;
        end else if (sr_neg) begin
          fc_we = 1'b1; fc_wd = cf_k;
        end
      end
      S_MB: fc_we = 1'b1;
      S_B9: begin
        fc_we = dv_rsp.done; fc_wd = dv_rsp.res;
      end
      default: fc_we = 1'b0;
    endcase
  end

  hec_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  hec_dvsq u_dvsq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dv_req),
    .a_i    (dv_a),
    .b_i    (dv_b),
    .rsp_o  (dv_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= S_IDLE;
      k_q         <= '0;
      cells_q     <= '0;
      lwait_q     <= 1'b0;
      sat_q       <= 1'b0;
      cfault_q    <= 1'b0;
      pcfault_q   <= 1'b0;
      cif_q       <= 1'b0;
      pif_flt_q   <= 1'b0;
      out_valid_q <= 1'b0;
      gamma_q     <= hec_pkg::GAMMA_RESET;
      dt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hec_pkg::CFG_GAMMA:      gamma_q <= cfg_wdata_i;
          hec_pkg::CFG_DT_OVER_DX: dt_q    <= cfg_wdata_i[hec_pkg::DT_BITS-1:0];
          default:                 dt_q    <= dt_q;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (dv_req.start) begin
        lwait_q <= 1'b1;
      end else if (dv_rsp.done) begin
        lwait_q <= 1'b0;
      end
      sat_q <= sat_q | step_sat;
      case (pc_q)
        S_IDLE: begin
          if (in_acc) begin
            sat_q <= 1'b0;
            pc_q  <= S_VEL;
          end
        end
        S_VEL: begin
          if (rho_zero || dv_rsp.done) pc_q <= S_MV;
        end
        S_MV:   pc_q <= S_KE;
        S_KE:   pc_q <= S_ED;
        S_ED:   pc_q <= S_GM;
        S_GM:   pc_q <= S_PRES;
        S_PRES: pc_q <= S_GP;
        S_GP:   pc_q <= snd_skip ? S_F1 : S_GPR;
        S_GPR: begin
          if (dv_rsp.done) pc_q <= S_SND;
        end
        S_SND: begin
          if (dv_rsp.done) pc_q <= S_F1;
        end
        S_F1: pc_q <= S_EP;
        S_EP: pc_q <= S_F2;
        S_F2: begin
          cfault_q <= sat_q | alu_y.sat | rho_zero | pres_nonpos;
          pc_q     <= (cells_q == 2'd0) ? S_COMMIT : S_SL;
        end
        S_SL: begin
          sat_q <= alu_y.sat;
          pc_q  <= S_SR;
        end
        S_SR: begin
          k_q  <= '0;
          pc_q <= S_K;
        end
        S_K: begin
          if (sl_pos || sr_neg) begin
            k_q  <= k_last ? 2'd0 : k_q + 2'd1;
            pc_q <= k_last ? S_IFLT : S_K;
          end else begin
            pc_q <= sr_eq_sl ? S_MA : S_B1;
          end
        end
        S_MA: pc_q <= S_MB;
        S_MB: begin
          k_q  <= k_last ? 2'd0 : k_q + 2'd1;
          pc_q <= k_last ? S_IFLT : S_K;
        end
        S_B1: pc_q <= S_B2;
        S_B2: pc_q <= S_B3;
        S_B3: pc_q <= S_B4;
        S_B4: pc_q <= S_B5;
        S_B5: pc_q <= S_B6;
        S_B6: pc_q <= S_B7;
        S_B7: pc_q <= S_B8;
        S_B8: pc_q <= S_B9;
        S_B9: begin
          if (dv_rsp.done) begin
            k_q  <= k_last ? 2'd0 : k_q + 2'd1;
            pc_q <= k_last ? S_IFLT : S_K;
          end
        end
        S_IFLT: begin
          cif_q <= sat_q | pcfault_q | cfault_q;
          sat_q <= 1'b0;
          k_q   <= '0;
          pc_q  <= (cells_q == 2'd2) ? S_U1 : S_COMMIT;
        end
        S_U1: pc_q <= S_U2;
        S_U2: pc_q <= S_U3;
        S_U3: begin
          k_q  <= k_last ? 2'd0 : k_q + 2'd1;
          pc_q <= k_last ? S_OUT : S_U1;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            pc_q        <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (row_end_q) begin
            cells_q <= 2'd0;
          end else begin
            cells_q   <= (cells_q == 2'd0) ? 2'd1 : 2'd2;
            pcfault_q <= cfault_q;
            pif_flt_q <= cif_q;
          end
          pc_q <= S_IDLE;
        end
        default: pc_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fc_we) begin
      case (k_q)
        2'd0:    fc0_q <= fc_wd;
        2'd1:    fc1_q <= fc_wd;
        default: fc2_q <= fc_wd;
      endcase
    end
    case (pc_q)
      S_IDLE: begin
        if (in_acc) begin
          cu0_q     <= hec_pkg::word_t'({1'b0, density_i});
          cu1_q     <= momentum_i;
          cu2_q     <= hec_pkg::word_t'({1'b0, energy_i});
          row_end_q <= row_end_i;
        end
      end
      S_VEL: begin
        if (rho_zero) begin
          vel_q <= '0;
        end else if (dv_rsp.done) begin
          vel_q <= dv_rsp.res;
        end
      end
      S_MV:   t1_q   <= alu_y.res;
      S_KE:   t2_q   <= alu_y.res;
      S_ED:   t2_q   <= alu_y.res;
      S_GM:   t3_q   <= alu_y.res;
      S_PRES: pres_q <= alu_y.res;
      S_GP: begin
        if (snd_skip) begin
          snd_q <= '0;
        end else begin
          t3_q <= alu_y.res;
        end
      end
      S_GPR: begin
        if (dv_rsp.done) t3_q <= dv_rsp.res;
      end
      S_SND: begin
        if (dv_rsp.done) snd_q <= dv_rsp.res;
      end
      S_F1: cf1_q <= alu_y.res;
      S_EP: t2_q  <= alu_y.res;
      S_F2: cf2_q <= alu_y.res;
      S_SL: sl_q  <= alu_y.res;
      S_SR: sr_q  <= alu_y.res;
      S_MA: t1_q  <= alu_y.res;
      S_B1: ta_q  <= alu_y.res;
      S_B2: tb_q  <= alu_y.res;
      S_B3: ta_q  <= alu_y.res;
      S_B4: tb_q  <= alu_y.res;
      S_B5: t2_q  <= alu_y.res;
      S_B6: tb_q  <= alu_y.res;
      S_B7: ta_q  <= alu_y.res;
      S_B8: tb_q  <= alu_y.res;
      S_U1: t1_q  <= alu_y.res;
      S_U2: t1_q  <= alu_y.res;
      S_U3: begin
        case (k_q)
          2'd0:    nv0_q <= alu_y.res;
          2'd1:    nv1_q <= alu_y.res;
          default: nv2_q <= alu_y.res;
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          od_q <= nv0_q[W-1] ? '0 : nv0_q[hec_pkg::FIELD_BITS-1:0];
          om_q <= nv1_q;
          oe_q <= nv2_q[W-1] ? '0 : nv2_q[hec_pkg::FIELD_BITS-1:0];
          of_q <= pif_flt_q | cif_q | sat_q | nv0_q[W-1] | nv2_q[W-1];
          ol_q <= row_end_q;
        end
      end
      S_COMMIT: begin
        if (!row_end_q) begin
          pu0_q  <= cu0_q;
          pu1_q  <= cu1_q;
          pu2_q  <= cu2_q;
          pvel_q <= vel_q;
          psnd_q <= snd_q;
          pf0_q  <= cu1_q;
          pf1_q  <= cf1_q;
          pf2_q  <= cf2_q;
          pif0_q <= fc0_q;
          pif1_q <= fc1_q;
          pif2_q <= fc2_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign new_density_o  = od_q;
  assign new_momentum_o = om_q;
  assign new_energy_o   = oe_q;
  assign fault_o        = of_q;
  assign last_cell_o    = ol_q;

  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(pc_q) == S_OUT) && ($past(cells_q) == 2'd2))
    else $error("result raised outside the update of a held cell");
  a_cells_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cells_q != 2'd3)
    else $error("cell count out of range");
  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_rsp.done |-> lwait_q && long_step)
    else $error("divider result arrived with no step waiting for it");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the HLL Euler cell update block with a built-in fixed-point predictor.
module tb;

  typedef struct {
    logic [hec_pkg::FIELD_BITS-1:0]       density;
    logic signed [hec_pkg::WORD_BITS-1:0] momentum;
    logic [hec_pkg::FIELD_BITS-1:0]       energy;
    logic                                 row_end;
  } cell_in_t;

  typedef struct {
    logic [hec_pkg::FIELD_BITS-1:0]       density;
    logic signed [hec_pkg::WORD_BITS-1:0] momentum;
    logic [hec_pkg::FIELD_BITS-1:0]       energy;
    logic                                 fault;
    logic                                 last_cell;
  } cell_upd_t;

  typedef struct {
    longint u[3];
    longint vel, pres, snd;
    longint flux[3];
    bit     fault;
  } cell_state_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint QONE = 64'sd1 << hec_pkg::FRAC_BITS;
  localparam longint QHALF = 64'sd1 << (hec_pkg::FRAC_BITS - 1);
  localparam int DRAIN_CYCLES = 500;
  localparam int LIMIT_CYCLES = 6000000;
  localparam int HOLD_CYCLES = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  hec_pkg::cfg_reg_e cfg_idx_i = hec_pkg::CFG_GAMMA;
  logic [hec_pkg::GAMMA_BITS-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [hec_pkg::FIELD_BITS-1:0] density_i = '0;
  logic signed [hec_pkg::WORD_BITS-1:0] momentum_i = '0;
  logic [hec_pkg::FIELD_BITS-1:0] energy_i = '0;
  logic row_end_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [hec_pkg::FIELD_BITS-1:0] new_density_o;
  logic signed [hec_pkg::WORD_BITS-1:0] new_momentum_o;
  logic [hec_pkg::FIELD_BITS-1:0] new_energy_o;
  logic fault_o;
  logic last_cell_o;

  hll_euler_cell_update dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i(cfg_idx_i), .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .density_i, .momentum_i, .energy_i, .row_end_i,
    .out_valid_o, .out_stall_i, .new_density_o, .new_momentum_o, .new_energy_o,
    .fault_o, .last_cell_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cell_in_t  cells_pending[$];
  cell_upd_t updates_expected[$];
  int errors = 0;
  int cells_sent = 0;
  int updates_seen = 0;
  int faults_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  // Predictor copy of configuration and row state.
  longint gamma_q;
  longint dt_q;
  int row_phase;
  cell_state_t held_cell;
  longint held_iface[3];
  bit held_iface_fault;
  bit sat_flag;

  function automatic longint clip(longint a);
    if (a > QMAX) begin
      sat_flag = 1'b1;
      return QMAX;
    end
    if (a < QMIN) begin
      sat_flag = 1'b1;
      return QMIN;
    end
    return a;
  endfunction

  function automatic longint unsigned magn(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  function automatic longint signed_of(bit neg, longint unsigned m);
    if (neg) begin
      if (m == 0) return 0;
      if (m > 64'd2147483648) begin
        sat_flag = 1'b1;
        return QMIN;
      end
      return -longint'(m);
    end
    if (m > 64'd2147483647) begin
      sat_flag = 1'b1;
      return QMAX;
    end
    return longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned m;
    m = magn(a) * magn(b);
    m = (m + (64'd1 << (hec_pkg::FRAC_BITS - 1))) >> hec_pkg::FRAC_BITS;
    return signed_of((a < 0) != (b < 0), m);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    longint unsigned mb, n;
    mb = magn(b);
    if (mb == 0) begin
      sat_flag = 1'b1;
      return 0;
    end
    n = (magn(a) << hec_pkg::FRAC_BITS) + mb / 2;
    return signed_of((a < 0) != (b < 0), n / mb);
  endfunction

  function automatic longint fx_sqrt(longint a);
    longint unsigned x, r, b;
    if (a <= 0) return 0;
    x = longint'(a) << hec_pkg::FRAC_BITS;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return signed_of(1'b0, r);
  endfunction

  function automatic cell_state_t cell_physics(cell_in_t c);
    cell_state_t s;
    longint rho, m, e;
    sat_flag = 1'b0;
    rho = longint'(c.density);
    m = longint'(c.momentum);
    e = longint'(c.energy);
    s.u[0] = rho;
    s.u[1] = m;
    s.u[2] = e;
    s.vel = rho > 0 ? fx_div(m, rho) : 0;
    s.pres = fx_mul(clip(gamma_q - QONE), clip(e - fx_mul(fx_mul(m, s.vel), QHALF)));
    s.snd = (rho > 0 && s.pres > 0) ? fx_sqrt(fx_div(fx_mul(gamma_q, s.pres), rho)) : 0;
    s.flux[0] = m;
    s.flux[1] = clip(fx_mul(m, s.vel) + s.pres);
    s.flux[2] = fx_mul(s.vel, clip(e + s.pres));
    s.fault = sat_flag || rho <= 0 || s.pres <= 0;
    return s;
  endfunction

  function automatic bit predict_update(cell_in_t c, output cell_upd_t r);
    cell_state_t s;
    longint fc[3], nv[3], sl, sr, num;
    bit ifault, f, produced;
    produced = 1'b0;
    r = '{default: '0};
    s = cell_physics(c);
    if (row_phase == 0) begin
      if (!c.row_end) begin
        held_cell = s;
        row_phase = 1;
      end
      return 1'b0;
    end
    sat_flag = 1'b0;
    sl = clip(held_cell.vel - held_cell.snd);
    sr = clip(s.vel + s.snd);
    for (int k = 0; k < 3; k++) begin
      if (sl > 0) begin
        fc[k] = held_cell.flux[k];
      end else if (sr >= 0) begin
        if (sr == sl) begin
          fc[k] = fx_mul(clip(held_cell.flux[k] + s.flux[k]), QHALF);
        end else begin
          num = clip(fx_mul(sr, held_cell.flux[k]) - fx_mul(sl, s.flux[k]));
          num = clip(num + fx_mul(fx_mul(sl, sr), clip(s.u[k] - held_cell.u[k])));
          fc[k] = fx_div(num, clip(sr - sl));
        end
      end else begin
        fc[k] = s.flux[k];
      end
    end
    ifault = sat_flag || held_cell.fault || s.fault;
    if (row_phase >= 2) begin
      f = held_iface_fault || ifault;
      sat_flag = 1'b0;
      for (int k = 0; k < 3; k++)
        nv[k] = clip(held_cell.u[k] - fx_mul(dt_q, clip(fc[k] - held_iface[k])));
      f = f || sat_flag;
      if (nv[0] < 0) begin
        nv[0] = 0;
        f = 1'b1;
      end
      if (nv[2] < 0) begin
        nv[2] = 0;
        f = 1'b1;
      end
      r.density = nv[0][hec_pkg::FIELD_BITS-1:0];
      r.momentum = nv[1][hec_pkg::WORD_BITS-1:0];
      r.energy = nv[2][hec_pkg::FIELD_BITS-1:0];
      r.fault = f;
      r.last_cell = c.row_end;
      produced = 1'b1;
    end
    if (c.row_end) begin
      row_phase = 0;
    end else begin
      held_cell = s;
      for (int k = 0; k < 3; k++) held_iface[k] = fc[k];
      held_iface_fault = ifault;
      row_phase = 2;
    end
    return produced;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (update %0d)", what, got, want, updates_seen);
    errors++;
  endtask

  // Input driver: offers queued cells and runs the predictor on each accepted transaction.
  always @(posedge clk_i) begin
    cell_upd_t r;
    bit taken;
    taken = in_valid_i && !in_stall_o;
    if (taken) begin
      cells_sent++;
      if (predict_update('{density_i, momentum_i, energy_i, row_end_i}, r))
        updates_expected.push_back(r);
    end
    if (taken || !in_valid_i) begin
      if (cells_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cell_in_t c;
        c = cells_pending.pop_front();
        density_i <= c.density;
        momentum_i <= c.momentum;
        energy_i <= c.energy;
        row_end_i <= c.row_end;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_request && hold_left == 0) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Output monitor: compares each accepted transaction with the oldest predicted update.
  always @(posedge clk_i) begin
    cell_upd_t w;
    if (out_valid_o && !out_stall_i) begin
      updates_seen++;
      if (fault_o) faults_seen++;
      if (updates_expected.size() == 0) begin
        report_mismatch("unexpected update count", 1, 0);
      end else begin
        w = updates_expected.pop_front();
        if (new_density_o !== w.density) report_mismatch("density", new_density_o, w.density);
        if (new_momentum_o !== w.momentum)
          report_mismatch("momentum", new_momentum_o, w.momentum);
        if (new_energy_o !== w.energy) report_mismatch("energy", new_energy_o, w.energy);
        if (fault_o !== w.fault) report_mismatch("fault", fault_o, w.fault);
        if (last_cell_o !== w.last_cell) report_mismatch("last_cell", last_cell_o, w.last_cell);
      end
    end
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(hec_pkg::cfg_reg_e idx, logic [hec_pkg::GAMMA_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == hec_pkg::CFG_GAMMA) gamma_q = longint'(val);
    else dt_q = longint'(val[hec_pkg::DT_BITS-1:0]);
  endtask

  task automatic add_cell(logic [30:0] d, logic signed [31:0] m, logic [30:0] e, logic re);
    cells_pending.push_back('{d, m, e, re});
  endtask

  task automatic add_random_row();
    int len;
    logic [30:0] d, e;
    logic signed [31:0] m;
    len = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(2, 6);
    for (int i = 0; i <= len; i++) begin
      if ($urandom_range(9) == 0) begin
        d = hec_pkg::FIELD_BITS'($urandom);
        m = $urandom;
        e = hec_pkg::FIELD_BITS'($urandom);
      end else begin
        d = hec_pkg::FIELD_BITS'($urandom_range(32'h0400000, 32'h4000000));
        m = $signed($urandom_range(0, 32'h4000000)) - 32'sh2000000;
        e = hec_pkg::FIELD_BITS'($urandom_range(32'h1000000, 32'h10000000));
      end
      add_cell(d, m, e, i == len);
    end
    if ($urandom_range(19) == 0)
      add_cell(hec_pkg::FIELD_BITS'($urandom), $urandom, hec_pkg::FIELD_BITS'($urandom), 1'b1);
  endtask

  task automatic wait_idle();
    while (!(cells_pending.size() == 0 && !in_valid_i && updates_expected.size() == 0))
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    gamma_q = longint'(hec_pkg::GAMMA_RESET);
    dt_q = 0;
    row_phase = 0;
    held_iface_fault = 1'b0;
    held_cell = '{default: 0, u: '{0, 0, 0}, flux: '{0, 0, 0}};
    held_iface = '{0, 0, 0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(hec_pkg::CFG_DT_OVER_DX, 26'd1 << 22);

    // Directed: lone row end, ghost-only row, field extremes, zero spread, supersonic flow.
    add_cell(31'd16777216, 32'sd0, 31'd33554432, 1'b1);
    add_cell(31'd16777216, 32'sd0, 31'd33554432, 1'b0);
    add_cell(31'd16777216, 32'sd0, 31'd33554432, 1'b1);
    add_cell(31'd0, 32'sd0, 31'd0, 1'b0);
    add_cell(31'd0, 32'sd0, 31'd0, 1'b0);
    add_cell(31'd0, 32'sd0, 31'd0, 1'b0);
    add_cell(31'h7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 1'b0);
    add_cell(31'h7FFFFFFF, -32'sh80000000, 31'h7FFFFFFF, 1'b0);
    add_cell(31'd1, -32'sh80000000, 31'd0, 1'b0);
    add_cell(31'd16777216, 32'sd0, 31'd25165824, 1'b1);
    add_cell(31'd16777216, 32'sd167772160, 31'd1006632960, 1'b0);
    add_cell(31'd16777216, 32'sd167772160, 31'd1006632960, 1'b0);
    add_cell(31'd16777216, 32'sd167772160, 31'd1006632960, 1'b1);
    add_cell(31'd16777216, -32'sd167772160, 31'd1006632960, 1'b0);
    add_cell(31'd16777216, -32'sd167772160, 31'd1006632960, 1'b0);
    add_cell(31'd8388608, -32'sd167772160, 31'd100663296, 1'b0);
    add_cell(31'd33554432, 32'sd1677722, 31'd50331648, 1'b0);
    add_cell(31'd16777216, 32'sd0, 31'd16777216, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      int n;
      case (p)
        0: begin
          write_reg(hec_pkg::CFG_GAMMA, 26'd16777217);
          write_reg(hec_pkg::CFG_DT_OVER_DX, 26'd16777216);
        end
        1: begin
          write_reg(hec_pkg::CFG_GAMMA, 26'd50331648);
          write_reg(hec_pkg::CFG_DT_OVER_DX, 26'd0);
        end
        2: write_reg(hec_pkg::CFG_GAMMA, hec_pkg::GAMMA_RESET);
        3: write_reg(hec_pkg::CFG_DT_OVER_DX,
                     hec_pkg::GAMMA_BITS'($urandom_range(16777216)));
        4: write_reg(hec_pkg::CFG_GAMMA,
                     hec_pkg::GAMMA_BITS'($urandom_range(16777217, 50331648)));
        default: write_reg(hec_pkg::CFG_DT_OVER_DX,
                           hec_pkg::GAMMA_BITS'($urandom_range(1 << 20)));
      endcase
      send_idle_pct = (p < 2) ? 28 : (p < 4) ? 46 : 0;
      recv_idle_pct = (p < 2) ? 46 : (p < 4) ? 28 : 0;
      if (p == 1) hold_request = 1'b1;
      n = 0;
      while (n < 330) begin
        add_random_row();
        n = cells_pending.size();
      end
      if (p == 1) repeat (2) @(posedge clk_i);
      hold_request = 1'b0;
      wait_idle();
    end

    $display("Sent %0d cells and checked %0d updates (%0d with fault) over several settings",
             cells_sent, updates_seen, faults_seen);
    $display("of gamma and dt_over_dx, with sender and receiver idling and a long output stall.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
